FILE: sv/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/ptrt_pkg.sv
// types, codes and sizes of the periodic task release table
package ptrt_pkg;

  localparam int DEF_MAX_TASKS = 8;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_EXEC   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_PER  = 2'd2;
  localparam logic [1:0] STAT_NULL_ID  = 2'd3;

  localparam logic [1:0] TASK_READY     = 2'd0;
  localparam logic [1:0] TASK_BLOCKED   = 2'd1;
  localparam logic [1:0] TASK_SUSPENDED = 2'd2;

  localparam logic [7:0] MAX_PERIOD_RST = 8'd255;
  localparam logic [7:0] TICKS_START    = 8'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] task_id;
    logic [7:0] period;
    logic [1:0] run_state;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       dispatch_valid;
    logic [7:0] dispatch_id;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ident;
    logic [7:0] period;
    logic [1:0] status;
    logic [7:0] ticks;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CREATE,
    S_WALK,
    S_FIN
  } state_t;

endpackage

FILE: sv/ptrt_ram.sv
// generic single-write single-read ram with registered read data
module ptrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/periodic_task_release_table_core.sv
// Periodic task release table: one transaction on in_data is one command.
// Create writes the new entry if its checks pass and offers the result through
// the output register once that is free. Set state, tick and execute walk the
// occupied entries through the task table ram, one entry per cycle on its single
// read port while out_ready does not hold back a pending result, with each entry
// written back once its read data is in hand. Execute gives one transaction per
// ready task in index order, the final one flagged with last, or a single
// transaction with dispatch_valid low if none is ready. The result sits in an
// output register, so out_ready may stall freely. The user writes the max_period
// register through cfg_data only while idle; the block does not enforce it.
module periodic_task_release_table_core import ptrt_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

  state_t           state, state_next;
  in_item_t         cmd;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] proc_idx;
  logic             rd_vld;
  logic             pend_vld;
  logic [7:0]       pend_id;
  logic [7:0]       max_period;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata, ram_rdata;

  logic             slot_free;
  logic             emit;
  out_item_t        emit_data;
  logic             stall;
  logic             walk_done;
  logic             take_ready;
  logic             create_ok;
  logic [1:0]       create_status;
  entry_t           upd;
  logic             need_emit;

  assign slot_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  ptrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // create checks in priority order
  always_comb begin
    priority if (used >= CNT_MAX) begin
      create_status = STAT_FULL;
    end else if (cmd.period == 8'd0 || cmd.period > max_period) begin
      create_status = STAT_BAD_PER;
    end else if (cmd.task_id == 8'd0) begin
      create_status = STAT_NULL_ID;
    end else begin
      create_status = STAT_OK;
    end
    create_ok = (create_status == STAT_OK);
  end

  // per-entry modify step of the walk
  always_comb begin
    upd       = ram_rdata;
    need_emit = 1'b0;
    unique case (cmd.opcode)
      OP_SET: begin
        if (ram_rdata.ident == cmd.task_id) begin
          upd.status = cmd.run_state;
        end
      end
      OP_TICK: begin
        if (ram_rdata.ticks >= ram_rdata.period && ram_rdata.status != TASK_SUSPENDED) begin
          upd.status = TASK_READY;
          upd.ticks  = TICKS_START;
        end else begin
          upd.ticks = ram_rdata.ticks + 8'd1;
        end
      end
      OP_EXEC: begin
        if (ram_rdata.status == TASK_READY) begin
          upd.status = TASK_BLOCKED;
          need_emit  = pend_vld;
        end
      end
      OP_CREATE: begin
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = proc_idx;
    ram_wdata  = upd;
    ram_re     = 1'b0;
    emit       = 1'b0;
    emit_data  = '0;
    stall      = 1'b0;
    walk_done  = 1'b0;
    take_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CREATE: begin
        emit_data.status = create_status;
        emit_data.last   = 1'b1;
        if (slot_free) begin
          emit = 1'b1;
          if (create_ok) begin
            ram_we    = 1'b1;
            ram_waddr = used[IDX_W-1:0];
            ram_wdata = '{ident: cmd.task_id, period: cmd.period,
                          status: cmd.run_state, ticks: TICKS_START};
          end
        end
      end
      S_WALK: begin
        // an earlier ready task goes out once a later one shows it is not last
        stall                    = rd_vld && need_emit && !slot_free;
        emit_data.status         = STAT_OK;
        emit_data.dispatch_valid = 1'b1;
        emit_data.dispatch_id    = pend_id;
        emit_data.last           = 1'b0;
        if (rd_vld && !stall) begin
          ram_we = 1'b1;
          emit   = need_emit;
          take_ready = (cmd.opcode == OP_EXEC) && (ram_rdata.status == TASK_READY);
        end
        ram_re    = !stall && (idx < used);
        walk_done = !rd_vld && (idx >= used);
      end
      S_FIN: begin
        emit_data.status = STAT_OK;
        emit_data.last   = 1'b1;
        if (cmd.opcode == OP_EXEC && pend_vld) begin
          emit_data.dispatch_valid = 1'b1;
          emit_data.dispatch_id    = pend_id;
        end
        emit = slot_free;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.opcode == OP_CREATE) ? S_CREATE : S_WALK;
        end
      end
      S_CREATE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
      pend_vld   <= 1'b0;
      out_valid  <= 1'b0;
      max_period <= MAX_PERIOD_RST;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        max_period <= cfg_data;
      end
      if (state == S_IDLE && in_valid) begin
        idx      <= '0;
        rd_vld   <= 1'b0;
        pend_vld <= 1'b0;
      end
      if (state == S_CREATE && slot_free && create_ok) begin
        used <= used + CNT_W'(1);
      end
      if (state == S_WALK && !stall) begin
        rd_vld <= ram_re;
        if (ram_re) begin
          idx <= idx + CNT_W'(1);
        end
      end
      if (take_ready) begin
        pend_vld <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd <= in_data;
    end
    if (state == S_WALK && !stall) begin
      proc_idx <= idx[IDX_W-1:0];
    end
    if (take_ready) begin
      pend_id <= ram_rdata.ident;
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

endmodule

FILE: sv/ptrt_checker.sv
// port-level checks of the periodic task release table and their bind
`include "assert_macros.svh"

module ptrt_checker import ptrt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // one command at a time: a transaction in closes the input side
  `ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready)

  // only dispatches can be followed by more results of the same command
  `ASSERT_SAME(a_last_only_dispatch, out_valid && !out_data.last, out_data.dispatch_valid)

  // a dispatch always carries an ok status
  `ASSERT_SAME(a_dispatch_ok, out_valid && out_data.dispatch_valid, out_data.status == STAT_OK)

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind periodic_task_release_table_core ptrt_checker u_ptrt_checker (.*);

FILE: tb/sv/periodic_task_release_table_checker.sv
// scoreboard for the periodic task release table: predicts every result and compares
module periodic_task_release_table_checker import ptrt_pkg::*; #(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [7:0] cfg_data,
  output int        errors,
  output int        pending,
  output int        results,
  output int        dispatches
);

  entry_t      slots [MAX_TASKS];
  int          slots_used;
  logic [7:0]  max_per;
  out_item_t   owed_results [$];
  int          err_cnt;
  int          res_cnt;
  int          disp_cnt;

  function automatic out_item_t mk_result(logic [1:0] st, logic dv, logic [7:0] id, logic lst);
    out_item_t r;
    r.status = st;
    r.dispatch_valid = dv;
    r.dispatch_id = id;
    r.last = lst;
    return r;
  endfunction

  // table update and results for one accepted command
  task automatic run_command(input in_item_t c);
    int last_rdy;
    last_rdy = -1;
    unique case (c.opcode)
      OP_CREATE: begin
        if (slots_used >= MAX_TASKS) begin
          owed_results.push_back(mk_result(STAT_FULL, 1'b0, 8'd0, 1'b1));
        end else if (c.period == 8'd0 || c.period > max_per) begin
          owed_results.push_back(mk_result(STAT_BAD_PER, 1'b0, 8'd0, 1'b1));
        end else if (c.task_id == 8'd0) begin
          owed_results.push_back(mk_result(STAT_NULL_ID, 1'b0, 8'd0, 1'b1));
        end else begin
          slots[slots_used].ident = c.task_id;
          slots[slots_used].period = c.period;
          slots[slots_used].status = c.run_state;
          slots[slots_used].ticks = TICKS_START;
          slots_used++;
          owed_results.push_back(mk_result(STAT_OK, 1'b0, 8'd0, 1'b1));
        end
      end
      OP_SET: begin
        for (int i = 0; i < slots_used; i++)
          if (slots[i].ident == c.task_id) slots[i].status = c.run_state;
        owed_results.push_back(mk_result(STAT_OK, 1'b0, 8'd0, 1'b1));
      end
      OP_TICK: begin
        for (int i = 0; i < slots_used; i++) begin
          if (slots[i].ticks >= slots[i].period && slots[i].status != TASK_SUSPENDED) begin
            slots[i].status = TASK_READY;
            slots[i].ticks = TICKS_START;
          end else begin
            slots[i].ticks = slots[i].ticks + 8'd1;
          end
        end
        owed_results.push_back(mk_result(STAT_OK, 1'b0, 8'd0, 1'b1));
      end
      default: begin
        for (int i = 0; i < slots_used; i++)
          if (slots[i].status == TASK_READY) last_rdy = i;
        if (last_rdy < 0) begin
          owed_results.push_back(mk_result(STAT_OK, 1'b0, 8'd0, 1'b1));
        end else begin
          for (int i = 0; i < slots_used; i++) begin
            if (slots[i].status == TASK_READY) begin
              owed_results.push_back(mk_result(STAT_OK, 1'b1, slots[i].ident, i == last_rdy));
              slots[i].status = TASK_BLOCKED;
            end
          end
        end
      end
    endcase
  endtask

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      slots_used = 0;
      max_per = MAX_PERIOD_RST;
      owed_results.delete();
      err_cnt = 0;
      res_cnt = 0;
      disp_cnt = 0;
    end else begin
      // compare before predicting so a stray result never meets a fresh expectation
      if (out_valid && out_ready) begin
        res_cnt++;
        if (out_data.dispatch_valid === 1'b1) disp_cnt++;
        if (owed_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = owed_results.pop_front();
          check_field("status", 8'(want.status), 8'(out_data.status));
          check_field("dispatch_valid", 8'(want.dispatch_valid), 8'(out_data.dispatch_valid));
          check_field("dispatch_id", want.dispatch_id, out_data.dispatch_id);
          check_field("last", 8'(want.last), 8'(out_data.last));
        end
      end
      if (cfg_valid && cfg_ready) max_per = cfg_data;
      if (in_valid && in_ready) run_command(in_data);
    end
    errors <= err_cnt;
    pending <= owed_results.size();
    results <= res_cnt;
    dispatches <= disp_cnt;
  end

endmodule

FILE: tb/sv/periodic_task_release_table_core_test.sv
// stimulus, flow control and verdict for the periodic task release table
module periodic_task_release_table_core_test import ptrt_pkg::*;;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_ITEMS    = 330;
  localparam int MIN_TICKS     = 260;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic held = 1'b0;
  int   errors;
  int   pending;
  int   results;
  int   dispatches;
  int   n_cmds = 0;
  int   n_ticks = 0;
  int   n_settings = 0;
  logic [7:0] cur_max = MAX_PERIOD_RST;
  // id 1 stays out of the pool so its suspended counter runs through the wrap
  logic [7:0] id_pool [8] = '{8'h02, 8'h03, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'hFE, 8'h00};
  logic [7:0] phase_max [3] = '{8'd16, 8'd255, 8'd3};

  periodic_task_release_table_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  periodic_task_release_table_checker i_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .results    (results),
    .dispatches (dispatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic in_item_t mk_cmd(logic [1:0] op, logic [7:0] id, logic [7:0] per,
                                      logic [1:0] st);
    in_item_t c;
    c.opcode = op;
    c.task_id = id;
    c.period = per;
    c.run_state = st;
    return c;
  endfunction

  function automatic in_item_t rand_cmd();
    int pick;
    logic [1:0] op;
    logic [7:0] id;
    logic [7:0] per;
    pick = $urandom_range(99);
    // tick heavy so the suspended counter wraps within the item budget
    if (pick < 5) op = OP_CREATE;
    else if (pick < 12) op = OP_SET;
    else if (pick < 88) op = OP_TICK;
    else op = OP_EXEC;
    id = ($urandom_range(3) == 0) ? 8'($urandom) : id_pool[$urandom_range(7)];
    // mostly legal periods, now and then anything the field holds
    per = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(cur_max, 1));
    return mk_cmd(op, id, per, 2'($urandom_range(3)));
  endfunction

  // offer one command, with a random gap before it unless calm
  task automatic push_cmd(input in_item_t c);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 32) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_cmds++;
    if (c.opcode == OP_TICK) n_ticks++;
  endtask

  // register write only once the block has drained
  task automatic set_max_period(input logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_max = v;
    n_settings++;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    int k;
    @(posedge clk);
    while (rst) @(posedge clk);

    // empty table
    push_cmd(mk_cmd(OP_EXEC, 8'h00, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_TICK, 8'hFF, 8'hFF, TASK_SUSPENDED));
    push_cmd(mk_cmd(OP_SET, 8'h05, 8'h00, TASK_BLOCKED));
    // create error ordering
    push_cmd(mk_cmd(OP_CREATE, 8'h12, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_CREATE, 8'h00, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_CREATE, 8'h00, 8'h09, TASK_READY));
    push_cmd(mk_cmd(OP_CREATE, 8'hFF, 8'hFF, TASK_READY));
    push_cmd(mk_cmd(OP_CREATE, 8'h01, 8'h01, TASK_SUSPENDED));
    push_cmd(mk_cmd(OP_CREATE, 8'h55, 8'h01, 2'd3));
    // zero max_period rejects everything
    set_max_period(8'd0);
    push_cmd(mk_cmd(OP_CREATE, 8'h07, 8'h01, TASK_READY));
    set_max_period(8'd1);
    push_cmd(mk_cmd(OP_CREATE, 8'h09, 8'h02, TASK_READY));
    push_cmd(mk_cmd(OP_CREATE, 8'hAA, 8'h01, TASK_BLOCKED));
    push_cmd(mk_cmd(OP_TICK, 8'h00, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_EXEC, 8'h00, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_EXEC, 8'h00, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_SET, 8'h55, 8'h00, 2'd3));
    push_cmd(mk_cmd(OP_SET, 8'hAA, 8'h00, TASK_SUSPENDED));
    push_cmd(mk_cmd(OP_TICK, 8'h00, 8'h00, TASK_READY));
    push_cmd(mk_cmd(OP_EXEC, 8'h00, 8'h00, TASK_READY));

    for (int ph = 0; ph < 3; ph++) begin
      set_max_period(phase_max[ph]);
      if (ph == 0) calm <= 1'b1;
      if (ph == 1) hold_req <= 1'b1;
      k = 0;
      while (k < RAND_ITEMS / 3 || (ph == 2 && n_ticks < MIN_TICKS)) begin
        if (ph == 0 && k == 60) calm <= 1'b0;
        push_cmd(rand_cmd());
        k++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands (%0d ticks) over %0d max_period settings", n_cmds, n_ticks,
             n_settings);
    $display("checked %0d results, %0d of them task dispatches", results, dispatches);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
